// ===== rtl/core/c8ks_pkg.sv =====
// ----------------------------------------------------------------------------
// c8ks_pkg: ChaCha8 keystream block package
// Payload types, sigma constants and round helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package c8ks_pkg;

    localparam int DOUBLE_ROUNDS_DEF = 4;
    localparam int ADDR_W            = 5;

    localparam logic [ADDR_W-1:0] REG_KEY_LOW  = 5'h00;
    localparam logic [ADDR_W-1:0] REG_KEY_HIGH = 5'h08;
    localparam logic [ADDR_W-1:0] REG_NONCE    = 5'h10;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3120646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d36;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    typedef logic [31:0] word_t;
    typedef word_t [15:0] state_t;

    typedef struct packed {
        logic        mode;
        logic [63:0] position;
        logic        last_block;
        logic [63:0] data_0;
        logic [63:0] data_1;
        logic [63:0] data_2;
        logic [63:0] data_3;
        logic [63:0] data_4;
        logic [63:0] data_5;
        logic [63:0] data_6;
        logic [63:0] data_7;
    } in_item_t;

    typedef struct packed {
        logic [63:0] out_0;
        logic [63:0] out_1;
        logic [63:0] out_2;
        logic [63:0] out_3;
        logic [63:0] out_4;
        logic [63:0] out_5;
        logic [63:0] out_6;
        logic [63:0] out_7;
        logic        last_out;
    } out_item_t;

    // Pipeline stall/advance control between stages
    typedef struct packed {
        logic advance;
        logic flush;
    } pipe_ctl_t;

    function automatic word_t rotl(input word_t v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    // One half of a quarter round (first or second add/xor/rotate pair)
    function automatic logic [127:0] qr_half(input logic [127:0] abcd,
                                             input logic second);
        word_t a, b, c, d;
        a = abcd[127:96];
        b = abcd[95:64];
        c = abcd[63:32];
        d = abcd[31:0];
        a = a + b;
        d = rotl(d ^ a, second ? 8 : 16);
        c = c + d;
        b = rotl(b ^ c, second ? 7 : 12);
        qr_half = {a, b, c, d};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/chacha8_keystream_block.sv =====
// ----------------------------------------------------------------------------
// chacha8_keystream_block: pipelined ChaCha8 keystream generator
// One 64-byte block per cycle while the output is not stalled, 128-bit key, optional XOR with data.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  in        input      in_valid/in_ready  in_item_t (mode, position, data)
//  out       output     out_valid/out_ready out_item_t (out_0..7, last_out)
//  apb       input      psel/penable/pwrite key_low, key_high, nonce
//
//  Throughput is one transaction per cycle while the output is not held; the
//  stages are an entry stage, two stages per round and a feed-forward stage.
//  Reset clears only the valid bits and the key/nonce registers.
//  When the output is held, the whole pipeline freezes; nothing is lost or
//  duplicated. The pipeline moves when the output stage is empty or taken.
// ----------------------------------------------------------------------------
`default_nettype none
module chacha8_keystream_block
    import c8ks_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_item_t          in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_item,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [63:0]       pwdata,
    output logic [63:0]            prdata,
    output logic                   pready
);

    logic [63:0] key_low_reg, key_high_reg, nonce_reg;
    logic        wr_en;
    pipe_ctl_t   ctl;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            nonce_reg    <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr)
                REG_KEY_LOW:  key_low_reg  <= pwdata;
                REG_KEY_HIGH: key_high_reg <= pwdata;
                REG_NONCE:    nonce_reg    <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_KEY_LOW:  prdata = key_low_reg;
            REG_KEY_HIGH: prdata = key_high_reg;
            REG_NONCE:    prdata = nonce_reg;
            default:      prdata = '0;
        endcase
    end

    // Whole pipeline advances together; output register is the last stage
    assign ctl.advance = !out_valid || out_ready;
    assign ctl.flush   = 1'b0;
    assign in_ready    = ctl.advance;

    c8ks_round_chain #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .valid_in  (in_valid),
        .item_in   (in_item),
        .key_low   (key_low_reg),
        .key_high  (key_high_reg),
        .nonce     (nonce_reg),
        .valid_out (out_valid),
        .item_out  (out_item)
    );

    // A stalled result must stay put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // Input is refused exactly while a result is held
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready inconsistent with output stall");

endmodule
`default_nettype wire

// ===== rtl/core/c8ks_half_round.sv =====
// ----------------------------------------------------------------------------
// c8ks_half_round: one registered half of a column or diagonal round
// Applies four half quarter rounds in parallel and registers the state.
// ----------------------------------------------------------------------------
`default_nettype none
module c8ks_half_round
    import c8ks_pkg::*;
#(
    parameter bit DIAG   = 1'b0,
    parameter bit SECOND = 1'b0
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      advance,
    input  wire logic      valid_in,
    input  wire state_t    state_in,
    input  wire in_item_t  item_in,
    output logic           valid_reg,
    output state_t         state_reg,
    output in_item_t       item_reg
);

    state_t state_next;

    always_comb
    begin
        logic [127:0] r;
        state_next = state_in;
        for (int q = 0; q < 4; q++)
        begin
            int ia, ib, ic, id;
            ia = q;
            ib = DIAG ? 4 + ((q + 1) % 4) : 4 + q;
            ic = DIAG ? 8 + ((q + 2) % 4) : 8 + q;
            id = DIAG ? 12 + ((q + 3) % 4) : 12 + q;
            r = qr_half({state_in[ia], state_in[ib], state_in[ic], state_in[id]},
                        SECOND);
            state_next[ia] = r[127:96];
            state_next[ib] = r[95:64];
            state_next[ic] = r[63:32];
            state_next[id] = r[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
            item_reg  <= item_in;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/c8ks_round_chain.sv =====
// ----------------------------------------------------------------------------
// c8ks_round_chain: input, round and feed-forward pipeline
// Four register stages per double round, plus entry and finalisation stages.
// ----------------------------------------------------------------------------
`default_nettype none
module c8ks_round_chain
    import c8ks_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire pipe_ctl_t ctl,
    input  wire logic      valid_in,
    input  wire in_item_t  item_in,
    input  wire logic [63:0] key_low,
    input  wire logic [63:0] key_high,
    input  wire logic [63:0] nonce,
    output logic           valid_out,
    output out_item_t      item_out
);

    localparam int NST = 4 * DOUBLE_ROUNDS;

    logic     v   [NST+1];
    state_t   s   [NST+1];
    in_item_t it  [NST+1];
    state_t   init_reg [NST+1];

    logic      v0_reg;
    state_t    s0_reg;
    in_item_t  it0_reg;
    state_t    init_next;

    always_comb
    begin
        init_next[0]  = SIGMA0;
        init_next[1]  = SIGMA1;
        init_next[2]  = SIGMA2;
        init_next[3]  = SIGMA3;
        init_next[4]  = key_low[31:0];
        init_next[5]  = key_low[63:32];
        init_next[6]  = key_high[31:0];
        init_next[7]  = key_high[63:32];
        init_next[8]  = key_low[31:0];
        init_next[9]  = key_low[63:32];
        init_next[10] = key_high[31:0];
        init_next[11] = key_high[63:32];
        init_next[12] = item_in.position[31:0];
        init_next[13] = item_in.position[63:32];
        init_next[14] = nonce[31:0];
        init_next[15] = nonce[63:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (ctl.advance)
            v0_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            s0_reg  <= init_next;
            it0_reg <= item_in;
        end
    end

    assign v[0]        = v0_reg;
    assign s[0]        = s0_reg;
    assign it[0]       = it0_reg;
    assign init_reg[0] = s0_reg;

    // The starting words ride alongside for the feed-forward add
    for (genvar g = 0; g < NST; g++)
    begin : g_stage
        c8ks_half_round #(
            .DIAG   (((g / 2) % 2) == 1),
            .SECOND ((g % 2) == 1)
        ) u_hr (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (ctl.advance),
            .valid_in  (v[g]),
            .state_in  (s[g]),
            .item_in   (it[g]),
            .valid_reg (v[g+1]),
            .state_reg (s[g+1]),
            .item_reg  (it[g+1])
        );

        state_t init_d_reg;
        always_ff @(posedge clk)
        begin
            if (ctl.advance)
                init_d_reg <= init_reg[g];
        end
        assign init_reg[g+1] = init_d_reg;
    end

    logic      vf_reg;
    out_item_t of_reg;
    out_item_t of_next;
    state_t    ks;

    always_comb
    begin
        logic [63:0] m;
        for (int i = 0; i < 16; i++)
            ks[i] = s[NST][i] + init_reg[NST][i];
        m = {64{it[NST].mode}};
        of_next.out_0    = {ks[1],  ks[0]}  ^ (it[NST].data_0 & m);
        of_next.out_1    = {ks[3],  ks[2]}  ^ (it[NST].data_1 & m);
        of_next.out_2    = {ks[5],  ks[4]}  ^ (it[NST].data_2 & m);
        of_next.out_3    = {ks[7],  ks[6]}  ^ (it[NST].data_3 & m);
        of_next.out_4    = {ks[9],  ks[8]}  ^ (it[NST].data_4 & m);
        of_next.out_5    = {ks[11], ks[10]} ^ (it[NST].data_5 & m);
        of_next.out_6    = {ks[13], ks[12]} ^ (it[NST].data_6 & m);
        of_next.out_7    = {ks[15], ks[14]} ^ (it[NST].data_7 & m);
        of_next.last_out = it[NST].last_block;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vf_reg <= 1'b0;
        else if (ctl.flush)
            vf_reg <= 1'b0;
        else if (ctl.advance)
            vf_reg <= v[NST];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
            of_reg <= of_next;
    end

    assign valid_out = vf_reg;
    assign item_out  = of_reg;

endmodule
`default_nettype wire
